@@ rtl/cfs_pkg.sv @@
// Shared types for the circular FIFO with search: command and status codes.
// Used by cfs_front, cfs_back and circular_fifo_with_search.
package cfs_pkg;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_LIST    = 2'd2,
      CMD_SEARCH  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   localparam int unsigned CmdWidth    = 2;
   localparam int unsigned StatusWidth = 3;

endpackage

@@ rtl/cfs_front.sv @@
// Front end: accepts request transactions, picks the operand each command needs
// and holds them in a two-entry queue for the back end. Depends on cfs_pkg.
module cfs_front #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cfs_pkg::cmd_type      req_cmd,
   input  logic [DATA_WIDTH-1:0] req_data_value,
   input  logic [DATA_WIDTH-1:0] req_search_key,
   output logic                  op_valid,
   input  logic                  op_ready,
   output cfs_pkg::cmd_type      op_cmd,
   output logic [DATA_WIDTH-1:0] op_operand
);
   import cfs_pkg::*;

   cmd_type               cmd_ff     [2];
   logic [DATA_WIDTH-1:0] operand_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;
   logic [DATA_WIDTH-1:0] operand_sel;
   logic                  push, pop;

   always_comb begin
      unique case (req_cmd)
         CMD_SEARCH: operand_sel = req_search_key;
         default:    operand_sel = req_data_value;
      endcase
   end

   assign req_ready  = (fill_ff != 2'd2);
   assign op_valid   = (fill_ff != 2'd0);
   assign op_cmd     = cmd_ff[rd_ptr_ff];
   assign op_operand = operand_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff]     <= req_cmd;
         operand_ff[wr_ptr_ff] <= operand_sel;
      end
   end

endmodule

@@ rtl/cfs_back.sv @@
// Back end: ring-buffer storage, head and count, and the sequencer that carries out
// each command and drives the registered result. Depends on cfs_pkg.
module cfs_back #(
   parameter int unsigned DEPTH       = 8,
   parameter int unsigned DATA_WIDTH  = 32,
   parameter int unsigned SLOT_WIDTH  = 3,
   parameter int unsigned COUNT_WIDTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   output logic                   op_ready,
   input  cfs_pkg::cmd_type       op_cmd,
   input  logic [DATA_WIDTH-1:0]  op_operand,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cfs_pkg::status_type    rsp_status,
   output logic [SLOT_WIDTH-1:0]  rsp_slot,
   output logic [DATA_WIDTH-1:0]  rsp_value,
   output logic                   rsp_last
);
   import cfs_pkg::*;

   localparam int unsigned SumWidth = COUNT_WIDTH + 1;
   localparam logic [SLOT_WIDTH-1:0]  LastSlot  = SLOT_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FullCount = COUNT_WIDTH'(DEPTH);
   localparam logic [SumWidth-1:0]    DepthSum  = SumWidth'(DEPTH);

   typedef enum logic {S_IDLE, S_RUN} state_type;

   state_type              state_ff, state_in;
   logic [SLOT_WIDTH-1:0]  head_ff, head_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   cmd_type                cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]  operand_ff, operand_in;
   logic [COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic [SLOT_WIDTH-1:0]  cur_ff, cur_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [SLOT_WIDTH-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [DATA_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [DATA_WIDTH-1:0]  mem [DEPTH];
   logic [DATA_WIDTH-1:0]  rd_data_ff;
   logic                   mem_we;
   logic [SumWidth-1:0]    tail_sum;
   logic [SLOT_WIDTH-1:0]  tail_slot;
   logic                   out_free;
   logic                   emit;

   function automatic logic [SLOT_WIDTH-1:0] next_slot(input logic [SLOT_WIDTH-1:0] s);
      return (s == LastSlot) ? '0 : s + 1'b1;
   endfunction

   assign tail_sum  = SumWidth'(head_ff) + SumWidth'(count_ff);
   assign tail_slot = (tail_sum >= DepthSum) ? SLOT_WIDTH'(tail_sum - DepthSum)
                                             : SLOT_WIDTH'(tail_sum);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign op_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      operand_in    = operand_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      emit          = 1'b0;
      mem_we        = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            cur_in = head_ff;
            if (op_valid) begin
               cmd_in     = op_cmd;
               operand_in = op_operand;
               idx_in     = '0;
               state_in   = S_RUN;
            end
         end
         S_RUN: begin
            if (out_free) begin
               rsp_status_in = ST_OK;
               rsp_slot_in   = '0;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
            end
            unique case (cmd_ff)
               CMD_ENQUEUE: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (count_ff == FullCount) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
               CMD_DEQUEUE: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_value_in = rd_data_ff;
                        head_in      = next_slot(head_ff);
                        count_in     = count_ff - 1'b1;
                     end
                  end
               end
               CMD_LIST: begin
                  if (out_free) begin
                     emit = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                        state_in      = S_IDLE;
                     end else begin
                        rsp_slot_in  = cur_ff;
                        rsp_value_in = rd_data_ff;
                        rsp_last_in  = ((idx_ff + 1'b1) == count_ff);
                        if ((idx_ff + 1'b1) == count_ff) begin
                           state_in = S_IDLE;
                        end else begin
                           idx_in = idx_ff + 1'b1;
                           cur_in = next_slot(cur_ff);
                        end
                     end
                  end
               end
               CMD_SEARCH: begin
                  if (idx_ff == count_ff) begin
                     if (out_free) begin
                        emit          = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                        state_in      = S_IDLE;
                     end
                  end else if (rd_data_ff == operand_ff) begin
                     if (out_free) begin
                        emit          = 1'b1;
                        rsp_status_in = ST_FOUND;
                        rsp_slot_in   = cur_ff;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     cur_in = next_slot(cur_ff);
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      operand_ff    <= operand_in;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_slot] <= operand_ff;
      end
      rd_data_ff <= mem[cur_in];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ rtl/circular_fifo_with_search.sv @@
// A result passes the front-end queue, the back-end command register and the result
// register. Enqueue and dequeue pass the idle and run states of the sequencer; list
// and search step one stored entry per cycle (list only while the result output is free)
// through the entry memory's single read port. A two-entry queue buffers requests ahead.
// Reset empties the queue (head and count cleared); stored entries are not cleared.
module circular_fifo_with_search #(
   parameter int unsigned DEPTH      = 8,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // data_value, search_key, zero padding
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]               req_tdata,
   // cmd
   input  logic [cfs_pkg::CmdWidth-1:0]                    req_tuser,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // slot_index, item_value, zero padding
   output logic [(($clog2(DEPTH)+DATA_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   // status
   output logic [cfs_pkg::StatusWidth-1:0]                 rsp_tuser,
   output logic                                            rsp_tlast
);
   import cfs_pkg::*;

   localparam int unsigned SlotWidth  = $clog2(DEPTH);
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);
   localparam int unsigned RspWidth   = ((SlotWidth + DATA_WIDTH + 7) / 8) * 8;

   logic                  op_valid;
   logic                  op_ready;
   cmd_type               op_cmd;
   logic [DATA_WIDTH-1:0] op_operand;
   status_type            rsp_status;
   logic [SlotWidth-1:0]  rsp_slot;
   logic [DATA_WIDTH-1:0] rsp_value;

   cfs_front #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_cmd        (cmd_type'(req_tuser)),
      .req_data_value (req_tdata[DATA_WIDTH-1:0]),
      .req_search_key (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .op_valid       (op_valid),
      .op_ready       (op_ready),
      .op_cmd         (op_cmd),
      .op_operand     (op_operand)
   );

   cfs_back #(
      .DEPTH       (DEPTH),
      .DATA_WIDTH  (DATA_WIDTH),
      .SLOT_WIDTH  (SlotWidth),
      .COUNT_WIDTH (CountWidth)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op_cmd     (op_cmd),
      .op_operand (op_operand),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = RspWidth'({rsp_value, rsp_slot});

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for circular_fifo_with_search: directed table then random commands,
// results held to table entries or to a behavioural queue model under varied stream idling.
// Depends on rtl/cfs_pkg.sv and rtl/circular_fifo_with_search.sv.
module tb_top;
   import cfs_pkg::*;

   localparam int unsigned DEPTH      = 8;
   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned REQ_W      = ((2*DATA_WIDTH+7)/8)*8;
   localparam int unsigned RSP_W      = (($clog2(DEPTH)+DATA_WIDTH+7)/8)*8;
   localparam int unsigned NUM_ROWS   = 23;
   localparam int unsigned IDLE_LIMIT = 4000;
   localparam int unsigned HOLD_LEN   = 300;

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot;
      logic [31:0] value;
      logic        last;
   } fifo_result_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] data;
      logic [31:0] key;
      bit          typed;
      status_type  st;
      logic [2:0]  slot;
      logic [31:0] val;
   } table_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [1:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [2:0]       rsp_tuser;
   logic             rsp_tlast;

   logic [31:0]     queue_store [DEPTH];
   logic [2:0]      queue_head;
   int              queue_count;
   fifo_result_type pending_results [$];
   table_row_type   stimulus_rows [NUM_ROWS];

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  start_hold     = 1'b0;
   bit  hold_done      = 1'b0;
   int  hold_left      = 0;
   int  error_count    = 0;
   int  requests_sent  = 0;
   int  results_seen   = 0;
   int  n_full, n_empty, n_found, n_missing;
   int  idle_cycles    = 0;

   circular_fifo_with_search #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   task automatic push_result(input status_type st, input logic [2:0] slot,
                              input logic [31:0] value, input logic last);
      fifo_result_type r;
      r.status = st;
      r.slot   = slot;
      r.value  = value;
      r.last   = last;
      pending_results.push_back(r);
   endtask

   // Updates the queue model for one accepted command and, when asked, records its results.
   task automatic predict_fifo_op(input cmd_type cmd, input logic [31:0] data,
                                  input logic [31:0] key, input bit record);
      logic [2:0] s;
      bit         hit;
      hit = 1'b0;
      case (cmd)
         CMD_ENQUEUE: begin
            if (queue_count == DEPTH) begin
               n_full++;
               if (record) push_result(ST_FULL, 3'd0, 32'd0, 1'b1);
            end else begin
               queue_store[queue_head + 3'(queue_count)] = data;
               queue_count++;
               if (record) push_result(ST_OK, 3'd0, 32'd0, 1'b1);
            end
         end
         CMD_DEQUEUE: begin
            if (queue_count == 0) begin
               n_empty++;
               if (record) push_result(ST_EMPTY, 3'd0, 32'd0, 1'b1);
            end else begin
               if (record) push_result(ST_OK, 3'd0, queue_store[queue_head], 1'b1);
               queue_head = queue_head + 3'd1;
               queue_count--;
            end
         end
         CMD_LIST: begin
            if (queue_count == 0) begin
               n_empty++;
               if (record) push_result(ST_EMPTY, 3'd0, 32'd0, 1'b1);
            end else begin
               for (int i = 0; i < queue_count; i++) begin
                  s = queue_head + 3'(i);
                  if (record) push_result(ST_OK, s, queue_store[s], i == queue_count - 1);
               end
            end
         end
         default: begin
            for (int i = 0; i < queue_count && !hit; i++) begin
               s = queue_head + 3'(i);
               if (queue_store[s] == key) begin
                  hit = 1'b1;
                  n_found++;
                  if (record) push_result(ST_FOUND, s, 32'd0, 1'b1);
               end
            end
            if (!hit) begin
               n_missing++;
               if (record) push_result(ST_NOT_FOUND, 3'd0, 32'd0, 1'b1);
            end
         end
      endcase
   endtask

   // Offers one request and returns in the time step at which it is accepted.
   task automatic send_request(input cmd_type cmd, input logic [31:0] data,
                               input logic [31:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {key, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic run_random(input int count);
      cmd_type     cmd;
      logic [31:0] data;
      logic [31:0] key;
      int          bias;
      int          roll;
      for (int n = 0; n < count; n++) begin
         bias = ((n / 12) % 2 == 0) ? 65 : 25;
         roll = $urandom_range(99);
         if (roll < bias) begin
            cmd = CMD_ENQUEUE;
         end else begin
            roll = $urandom_range(99);
            cmd  = (roll < 45) ? CMD_DEQUEUE : (roll < 70) ? CMD_LIST : CMD_SEARCH;
         end
         data = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom();
         if (queue_count > 0 && $urandom_range(99) < 60) begin
            key = queue_store[queue_head + 3'($urandom_range(queue_count - 1))];
         end else begin
            key = ($urandom_range(1) == 0) ? 32'($urandom_range(3)) : $urandom();
         end
         send_request(cmd, data, key);
         predict_fifo_op(cmd, data, key, 1'b1);
      end
   endtask

   task automatic check_result();
      fifo_result_type want;
      if (pending_results.size() == 0) begin
         error_count++;
         $display("%0t: response with nothing expected: status %0d slot %0d value %h last %b",
                  $time, rsp_tuser, rsp_tdata[2:0], rsp_tdata[34:3], rsp_tlast);
      end else begin
         want = pending_results.pop_front();
         if (rsp_tuser !== want.status || rsp_tdata[2:0] !== want.slot
             || rsp_tdata[34:3] !== want.value || rsp_tlast !== want.last) begin
            error_count++;
            $display("%0t: mismatch: expected status %0d slot %0d value %h last %b",
                     $time, want.status, want.slot, want.value, want.last);
            $display("%0t:           actual status %0d slot %0d value %h last %b",
                     $time, rsp_tuser, rsp_tdata[2:0], rsp_tdata[34:3], rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            check_result();
         end
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (start_hold && !hold_done) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                  $time, idle_cycles, pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      n_full      = 0;
      n_empty     = 0;
      n_found     = 0;
      n_missing   = 0;
      queue_head  = 3'd0;
      queue_count = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_ENQUEUE;
      for (int i = 0; i < DEPTH; i++) queue_store[i] = 32'd0;

      // Empty-queue cases first, then fill to the limit, probe, and wrap the tail around.
      stimulus_rows = '{
         '{CMD_DEQUEUE, 32'h0,        32'h0,        1'b1, ST_EMPTY,     3'd0, 32'h0},
         '{CMD_LIST,    32'h0,        32'h0,        1'b1, ST_EMPTY,     3'd0, 32'h0},
         '{CMD_SEARCH,  32'h0,        32'h0,        1'b1, ST_NOT_FOUND, 3'd0, 32'h0},
         '{CMD_ENQUEUE, 32'h80000000, 32'h0,        1'b1, ST_OK,        3'd0, 32'h0},
         '{CMD_ENQUEUE, 32'h7fffffff, 32'h0,        1'b1, ST_OK,        3'd0, 32'h0},
         '{CMD_ENQUEUE, 32'h00000000, 32'h0,        1'b1, ST_OK,        3'd0, 32'h0},
         '{CMD_ENQUEUE, 32'hffffffff, 32'h0,        1'b1, ST_OK,        3'd0, 32'h0},
         '{CMD_ENQUEUE, 32'h00000005, 32'h0,        1'b1, ST_OK,        3'd0, 32'h0},
         '{CMD_ENQUEUE, 32'h55555555, 32'h0,        1'b1, ST_OK,        3'd0, 32'h0},
         '{CMD_ENQUEUE, 32'haaaaaaaa, 32'h0,        1'b1, ST_OK,        3'd0, 32'h0},
         '{CMD_ENQUEUE, 32'h00000005, 32'h0,        1'b1, ST_OK,        3'd0, 32'h0},
         '{CMD_ENQUEUE, 32'h12345678, 32'h0,        1'b1, ST_FULL,      3'd0, 32'h0},
         '{CMD_LIST,    32'h0,        32'h0,        1'b0, ST_OK,        3'd0, 32'h0},
         '{CMD_SEARCH,  32'hffffffff, 32'h00000005, 1'b1, ST_FOUND,     3'd4, 32'h0},
         '{CMD_SEARCH,  32'h0,        32'h80000000, 1'b1, ST_FOUND,     3'd0, 32'h0},
         '{CMD_SEARCH,  32'h0,        32'h7fffffff, 1'b0, ST_OK,        3'd0, 32'h0},
         '{CMD_SEARCH,  32'h0,        32'h00000006, 1'b0, ST_OK,        3'd0, 32'h0},
         '{CMD_DEQUEUE, 32'h0,        32'h0,        1'b1, ST_OK,        3'd0, 32'h80000000},
         '{CMD_ENQUEUE, 32'h0000002a, 32'hffffffff, 1'b0, ST_OK,        3'd0, 32'h0},
         '{CMD_LIST,    32'h0,        32'h0,        1'b0, ST_OK,        3'd0, 32'h0},
         '{CMD_SEARCH,  32'h0,        32'h0000002a, 1'b0, ST_OK,        3'd0, 32'h0},
         '{CMD_DEQUEUE, 32'h0,        32'h0,        1'b0, ST_OK,        3'd0, 32'h0},
         '{CMD_DEQUEUE, 32'h0,        32'h0,        1'b0, ST_OK,        3'd0, 32'h0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_ROWS; r++) begin
         send_request(stimulus_rows[r].cmd, stimulus_rows[r].data, stimulus_rows[r].key);
         predict_fifo_op(stimulus_rows[r].cmd, stimulus_rows[r].data, stimulus_rows[r].key,
                         !stimulus_rows[r].typed);
         if (stimulus_rows[r].typed) begin
            push_result(stimulus_rows[r].st, stimulus_rows[r].slot, stimulus_rows[r].val, 1'b1);
         end
      end

      run_random(20);
      send_idle_pct = 80;
      run_random(20);
      send_idle_pct  = 0;
      recv_stall_pct = 80;
      run_random(20);
      send_idle_pct  = 6;
      recv_stall_pct = 6;
      run_random(20);

      // The receiver now holds off for a long stretch while requests keep arriving.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      start_hold     = 1'b1;
      run_random(10);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Covered %0d requests and %0d responses: %0d full rejections, %0d empty,",
               requests_sent, results_seen, n_full, n_empty);
      $display("%0d searches found and %0d not found, under five idling patterns.",
               n_found, n_missing);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
